>>> design/servo_calibrated_position_command_defines.svh
// ----------------------------------------------------------------------------
// Servo command assertion macros
// Shared assertion helpers for the servo command block.
// ----------------------------------------------------------------------------
`ifndef SERVO_CALIBRATED_POSITION_COMMAND_DEFINES_SVH
`define SERVO_CALIBRATED_POSITION_COMMAND_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define SCPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define SCPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/scpc_pkg.sv
// ----------------------------------------------------------------------------
// Servo command package
// Shared widths, request codes, register indices, reset values and status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package scpc_pkg;
  localparam int MaxPointsDefault = 16;
  localparam int AngleW = 14;
  localparam int PulseW = 12;
  localparam int BusyW  = 20;
  localparam int CfgW   = 16;
  localparam int CfgIdxW = 3;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ANGLE = 2'd1,
    REQ_PULSE = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  localparam logic [CfgIdxW-1:0] CFG_POINT_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_PULSE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PULSE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MS_PER_DEG  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INIT_ANGLE  = 3'd4;

  localparam logic [4:0]         RST_POINT_COUNT = 5'd2;
  localparam logic [PulseW-1:0]  RST_MIN_PULSE   = 12'd500;
  localparam logic [PulseW-1:0]  RST_MAX_PULSE   = 12'd2500;
  localparam logic [15:0]        RST_MS_PER_DEG  = 16'd1280;
  localparam logic signed [AngleW-1:0] RST_INIT_ANGLE = 14'sd1440;
  localparam logic [PulseW-1:0]  PULSE_CEILING   = 12'd3000;
  localparam logic [BusyW-1:0]   BUSY_BASE       = 20'd10;
  localparam logic [BusyW-1:0]   BUSY_MAX        = 20'hFFFFF;

  // Status from the divider to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage
`default_nettype wire

>>> design/scpc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module scpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/scpc_div.sv
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring divider, one quotient bit per cycle, truncation toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module scpc_div
  import scpc_pkg::*;
#(
  parameter int NumW = 32,
  parameter int DenW = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic signed [NumW-1:0] num,
  input  wire logic signed [DenW-1:0] den,
  output logic signed [NumW-1:0]      quot,
  output div_stat_t                   stat
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q;
  logic [DenW:0]   rem;
  logic [DenW-1:0] dmag;
  logic            neg;
  logic [CntW-1:0] cnt;
  logic [DenW+1:0] trial;

  assign trial = {rem, q[NumW-1]} - {2'b00, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt  <= CntW'(NumW);
        q    <= num[NumW-1] ? NumW'(-num) : num;
        dmag <= den[DenW-1] ? DenW'(-den) : den;
        neg  <= num[NumW-1] ^ den[DenW-1];
        rem  <= '0;
      end else if (stat.busy) begin
        if (trial[DenW+1]) begin
          rem <= (DenW+1)'({rem, q[NumW-1]});
          q   <= {q[NumW-2:0], 1'b0};
        end else begin
          rem <= trial[DenW:0];
          q   <= {q[NumW-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? NumW'(-q) : q;
endmodule
`default_nettype wire

>>> design/scpc_core.sv
// ----------------------------------------------------------------------------
// Servo command sequencer
// Table search, interpolation and busy bookkeeping over the point RAMs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module scpc_core
  import scpc_pkg::*;
#(
  parameter int MaxPoints = MaxPointsDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                req_type,
  input  wire logic [3:0]                point_index,
  input  wire logic signed [AngleW-1:0]  angle_value,
  input  wire logic [PulseW-1:0]         pulse_value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           accepted,
  output logic [PulseW-1:0]              pulse_out,
  output logic signed [AngleW-1:0]       angle_out,
  output logic                           busy_res,
  input  wire logic                      cfg_we,
  input  wire logic [CfgIdxW-1:0]        cfg_index,
  input  wire logic [CfgW-1:0]           cfg_data
);
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  // Division by ten as a multiply: ceil(2^26 / 10), exact for the busy range.
  localparam logic [22:0] Recip10 = 23'd6710887;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIRST = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_BUSY  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [4:0]               point_count;
  logic [PulseW-1:0]        lo_limit, hi_limit;
  logic [15:0]              ms_per_deg;
  logic signed [AngleW-1:0] tracked_angle;
  logic [PulseW-1:0]        tracked_pulse;
  logic [BusyW-1:0]         busy_cnt;

  logic [1:0]               rtype;
  logic signed [AngleW-1:0] r_ang;
  logic [PulseW-1:0]        r_pul;
  logic signed [AngleW:0]   x;
  logic [CntW-1:0]          n_use;
  logic [CntW-1:0]          ridx;
  logic                     found;
  logic                     low_end;
  logic                     acc;
  logic signed [AngleW:0]   x0, y0, x1, y1;
  logic signed [AngleW:0]   prev_x, prev_y;
  logic signed [AngleW+1:0] dx;
  logic signed [31:0]       num;
  logic signed [31:0]       quot;
  div_stat_t                dstat;
  logic                     div_start;
  logic [33:0]              busy_prod;
  logic [45:0]              busy_recip;
  logic [BusyW:0]           busy_sum;

  logic                       we;
  logic [IdxW-1:0]            raddr;
  logic [AngleW-1:0]          a_rd;
  logic [PulseW-1:0]          p_rd;
  logic signed [AngleW:0]     rd_x, rd_y;

  assign we = in_valid && in_ready && req_t'(req_type) == REQ_LOAD
              && 32'(point_index) < MaxPoints;

  scpc_ram #(.Width(AngleW), .Depth(MaxPoints)) u_angle_ram (
    .clk(clk), .we(we), .waddr(IdxW'(point_index)), .wdata(angle_value),
    .raddr(raddr), .rdata(a_rd));
  scpc_ram #(.Width(PulseW), .Depth(MaxPoints)) u_pulse_ram (
    .clk(clk), .we(we), .waddr(IdxW'(point_index)), .wdata(pulse_value),
    .raddr(raddr), .rdata(p_rd));

  // x axis is angle for set angle, pulse for set pulse.
  always_comb begin
    if (req_t'(rtype) == REQ_ANGLE) begin
      rd_x = {a_rd[AngleW-1], a_rd};
      rd_y = {3'b000, p_rd};
    end else begin
      rd_x = {3'b000, p_rd};
      rd_y = {a_rd[AngleW-1], a_rd};
    end
  end

  assign raddr = IdxW'(ridx);
  assign in_ready = state == S_IDLE;
  assign dx = (AngleW+2)'(x1) - (AngleW+2)'(x0);
  assign div_start = state == S_MUL;

  // Numerator of the interpolation, settled while the divider is started.
  assign num = 32'(y0) * 32'(dx) + (32'(y1) - 32'(y0)) * (32'(x) - 32'(x0));

  scpc_div #(.NumW(32), .DenW(AngleW+2)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(dx),
    .quot(quot), .stat(dstat));

  logic signed [PulseW+1:0] p_res;
  logic signed [AngleW:0]   a_res;
  logic                     ok_p;
  logic signed [31:0]       y_res;

  assign y_res = (dx == '0) ? 32'(y0) : quot;
  assign p_res = (PulseW+2)'(y_res);
  assign a_res = (y_res > 32'sd8191) ? 15'sd8191 :
                 (y_res < -32'sd8192) ? -15'sd8192 : (AngleW+1)'(y_res);

  always_comb begin
    logic signed [32:0] pv;
    pv = (req_t'(rtype) == REQ_ANGLE) ? 33'(y_res) : 33'(r_pul);
    ok_p = pv >= 33'(lo_limit) && pv <= 33'(hi_limit) && pv > 33'sd0
           && pv < 33'(PULSE_CEILING);
  end

  logic signed [AngleW-1:0] new_ang;
  logic [AngleW:0]          dang;
  logic signed [AngleW:0]   dsig;
  assign new_ang = (req_t'(rtype) == REQ_ANGLE) ? r_ang : AngleW'(a_res);
  assign dsig = (AngleW+1)'(new_ang) - (AngleW+1)'(tracked_angle);
  assign dang = dsig[AngleW] ? (AngleW+1)'(-dsig) : dsig;

  // Busy time is (|delta| * ms_per_degree * 6 >> 11) / 10 + 10.
  assign busy_recip = 46'(busy_prod[33:11]) * 46'(Recip10);
  assign busy_sum   = (BusyW+1)'(busy_recip[45:26]) + (BusyW+1)'(BUSY_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      accepted      <= 1'b0;
      pulse_out     <= '0;
      angle_out     <= '0;
      busy_res      <= 1'b0;
      point_count   <= RST_POINT_COUNT;
      lo_limit      <= RST_MIN_PULSE;
      hi_limit      <= RST_MAX_PULSE;
      ms_per_deg    <= RST_MS_PER_DEG;
      tracked_angle <= RST_INIT_ANGLE;
      tracked_pulse <= '0;
      busy_cnt      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POINT_COUNT: point_count <= cfg_data[4:0];
          CFG_MIN_PULSE:   lo_limit    <= cfg_data[PulseW-1:0];
          CFG_MAX_PULSE:   hi_limit    <= cfg_data[PulseW-1:0];
          CFG_MS_PER_DEG:  ms_per_deg  <= cfg_data;
          CFG_INIT_ANGLE:  tracked_angle <= cfg_data[AngleW-1:0];
          default: ;
        endcase
      end
      // The response is captured into its own registers so that it holds
      // still while the next request is already being worked on.
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        accepted  <= acc;
        pulse_out <= tracked_pulse;
        angle_out <= tracked_angle;
        busy_res  <= busy_cnt != '0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rtype <= req_type;
            r_ang <= angle_value;
            r_pul <= pulse_value;
            ridx  <= '0;
            found <= 1'b0;
            if (point_count < 5'd2) n_use <= CntW'(2);
            else if (32'(point_count) > MaxPoints) n_use <= CntW'(MaxPoints);
            else n_use <= CntW'(point_count);
            if (req_t'(req_type) == REQ_ANGLE) x <= {angle_value[AngleW-1], angle_value};
            else x <= {3'b000, pulse_value};
            acc <= 1'b1;
            unique case (req_t'(req_type))
              REQ_LOAD: state <= S_OUT;
              REQ_TICK: begin
                if (busy_cnt != '0) busy_cnt <= busy_cnt - 1'b1;
                state <= S_OUT;
              end
              REQ_PULSE: begin
                if (pulse_value >= lo_limit && pulse_value <= hi_limit
                    && pulse_value != '0 && pulse_value < PULSE_CEILING) begin
                  state <= S_FIRST;
                end else begin
                  acc <= 1'b0;
                  state <= S_OUT;
                end
              end
              default: state <= S_FIRST;
            endcase
          end
        end
        S_FIRST: begin
          // Address 0 issued; data arrives next cycle.
          ridx  <= CntW'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          // rd_x/rd_y hold entry ridx-1. The final segment is used when x is above
          // the first point and at or above the last point, and also when nothing enclosed x.
          if (ridx == CntW'(1)) begin
            x0 <= rd_x; y0 <= rd_y;
            low_end <= x <= rd_x;
            if (x <= rd_x) found <= 1'b1;
          end else if (ridx == n_use && !low_end && x >= rd_x) begin
            x0 <= prev_x; y0 <= prev_y; x1 <= rd_x; y1 <= rd_y;
          end else if (!found) begin
            x0 <= prev_x; y0 <= prev_y; x1 <= rd_x; y1 <= rd_y;
            if (prev_x <= x && x <= rd_x) found <= 1'b1;
          end else if (ridx == CntW'(2)) begin
            x1 <= rd_x; y1 <= rd_y;
          end
          prev_x <= rd_x; prev_y <= rd_y;
          if (ridx == n_use) state <= S_MUL;
          ridx <= ridx + 1'b1;
        end
        S_MUL: state <= S_DIV;
        S_DIV: begin
          if (dstat.done || (dx == '0 && !dstat.busy)) begin
            if ((req_t'(rtype) == REQ_ANGLE) ? ok_p : 1'b1) begin
              busy_prod     <= 34'(dang) * 34'(ms_per_deg) * 34'd6;
              tracked_angle <= new_ang;
              tracked_pulse <= (req_t'(rtype) == REQ_ANGLE) ? PulseW'(p_res) : r_pul;
              state <= S_BUSY;
            end else begin
              acc <= 1'b0;
              state <= S_OUT;
            end
          end
        end
        S_BUSY: begin
          if (busy_sum > (BusyW+1)'(BUSY_MAX)) busy_cnt <= BUSY_MAX;
          else busy_cnt <= busy_sum[BusyW-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/servo_calibrated_position_command.sv
// ----------------------------------------------------------------------------
// Servo calibrated position command
// Maps angle or pulse requests through a calibration table in RAM.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         request: type, table index, angle, pulse
// m_axis    out        response: accepted flag, pulse, angle, busy flag
// cfg       in         register writes, index 0..4
// The table scan reads one RAM entry a cycle and the serial divider yields
// one bit a cycle. Load and tick requests go straight to the response.
// Reset is synchronous and restores the register defaults; the tables
// are left unset. The response sits in its own registers, so a stalled
// output lets one further request in and then holds the block at its output.
`timescale 1ns / 1ps
`default_nettype none
`include "servo_calibrated_position_command_defines.svh"
module servo_calibrated_position_command
  import scpc_pkg::*;
#(
  parameter int MaxPoints = MaxPointsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [3:0] point_index, [17:4] angle_value, [29:18] pulse_value, zero pad
  input  wire logic [31:0]         s_axis_tdata,
  // [1:0] req_type
  input  wire logic [1:0]          s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [11:0] pulse_out, [25:12] angle_out, [26] busy_res, zero pad
  output logic [31:0]              m_axis_tdata,
  // [0] accepted
  output logic                     m_axis_tuser,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgW-1:0]     cfg_data
);
  logic [PulseW-1:0]        pulse_out;
  logic signed [AngleW-1:0] angle_out;
  logic                     busy_res;

  // The core sequences the scan, multiply, divide and busy update.
  scpc_core #(.MaxPoints(MaxPoints)) u_core (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .req_type(s_axis_tuser), .point_index(s_axis_tdata[3:0]),
    .angle_value(s_axis_tdata[17:4]), .pulse_value(s_axis_tdata[29:18]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .accepted(m_axis_tuser), .pulse_out(pulse_out), .angle_out(angle_out),
    .busy_res(busy_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

  assign m_axis_tdata = {5'd0, busy_res, angle_out, pulse_out};

  `SCPC_ASSERT_NEXT(a_hold_off, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `SCPC_ASSERT_NEXT(a_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `SCPC_ASSERT_NEXT(a_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
endmodule
`default_nettype wire

>>> sim/servo_calibrated_position_command_tb.sv
// ----------------------------------------------------------------------------
// Servo calibrated position command testbench
// Loads calibration tables, then sends angle, pulse, load and tick requests
// under several register settings. A scoreboard predicts every response from
// its own copy of the table, tracked position and busy countdown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Holds the predicted servo state and the queue of expected responses.
class servo_cmd_scoreboard;
  typedef struct {
    logic              acc;
    logic [11:0]       pulse;
    logic [13:0]       angle;
    logic              busy;
  } servo_resp_t;

  servo_resp_t exp_q[$];
  int          ang_tbl[16];
  int          pul_tbl[16];
  int          trk_ang;
  int          trk_pul;
  int          busy_cnt;
  int          pt_count;
  int          min_pul;
  int          max_pul;
  int          ms_deg;
  int          fails;
  int          checked;

  function new();
    pt_count = 2;
    min_pul  = 500;
    max_pul  = 2500;
    ms_deg   = 1280;
    trk_ang  = 1440;
    trk_pul  = 0;
    busy_cnt = 0;
    fails    = 0;
    checked  = 0;
  endfunction

  function void configure(logic [2:0] idx, logic [15:0] data);
    case (idx)
      scpc_pkg::CFG_POINT_COUNT: pt_count = data[4:0];
      scpc_pkg::CFG_MIN_PULSE:   min_pul  = data[11:0];
      scpc_pkg::CFG_MAX_PULSE:   max_pul  = data[11:0];
      scpc_pkg::CFG_MS_PER_DEG:  ms_deg   = data;
      scpc_pkg::CFG_INIT_ANGLE:  trk_ang  = $signed(data[13:0]);
      default: ;
    endcase
  endfunction

  // Piecewise linear map of x through the xs/ys points, extrapolating from
  // the end segments and truncating toward zero.
  function longint map_through_table(int xs[16], int ys[16], longint x);
    int     n;
    int     k;
    longint den;
    longint num;
    n = (pt_count < 2) ? 2 : (pt_count > 16) ? 16 : pt_count;
    k = n - 2;
    if (x <= xs[0]) begin
      k = 0;
    end else if (x < xs[n-1]) begin
      for (int i = 1; i < n; i++) begin
        if (xs[i-1] <= x && x <= xs[i]) begin
          k = i - 1;
          break;
        end
      end
    end
    den = longint'(xs[k+1]) - xs[k];
    if (den == 0) return ys[k];
    num = longint'(ys[k]) * den + (longint'(ys[k+1]) - ys[k]) * (x - xs[k]);
    return num / den;
  endfunction

  function bit pulse_allowed(longint p);
    return p >= min_pul && p <= max_pul && p > 0 && p < 3000;
  endfunction

  function void move_to(int a, int p);
    longint d;
    longint t;
    d = longint'(a) - trk_ang;
    if (d < 0) d = -d;
    t = d * ms_deg * 6 / 20480 + 10;
    if (t > 64'hFFFFF) t = 64'hFFFFF;
    busy_cnt = int'(t);
    trk_ang  = a;
    trk_pul  = p & 12'hFFF;
  endfunction

  function void note_request(scpc_pkg::req_t kind, logic [3:0] idx,
                             logic [13:0] ang, logic [11:0] pul);
    servo_resp_t r;
    longint      v;
    int          a;
    a     = $signed(ang);
    r.acc = 1'b1;
    case (kind)
      scpc_pkg::REQ_LOAD: begin
        ang_tbl[idx] = a;
        pul_tbl[idx] = pul;
      end
      scpc_pkg::REQ_ANGLE: begin
        v = map_through_table(ang_tbl, pul_tbl, a);
        if (pulse_allowed(v)) move_to(a, int'(v));
        else r.acc = 1'b0;
      end
      scpc_pkg::REQ_PULSE: begin
        if (pulse_allowed(pul)) begin
          v = map_through_table(pul_tbl, ang_tbl, pul);
          if (v > 8191) v = 8191;
          if (v < -8192) v = -8192;
          move_to(int'(v), pul);
        end else begin
          r.acc = 1'b0;
        end
      end
      default: begin
        if (busy_cnt != 0) busy_cnt--;
      end
    endcase
    r.pulse = trk_pul[11:0];
    r.angle = trk_ang[13:0];
    r.busy  = (busy_cnt != 0);
    exp_q.push_back(r);
  endfunction

  function void check_response(logic acc, logic [31:0] data);
    servo_resp_t e;
    if (exp_q.size() == 0) begin
      $error("response with nothing expected: tuser=%0d tdata=%h", acc, data);
      fails++;
      return;
    end
    e = exp_q.pop_front();
    checked++;
    if (acc !== e.acc) begin
      $error("accepted: expected %0d, got %0d", e.acc, acc);
      fails++;
    end
    if (data[11:0] !== e.pulse) begin
      $error("pulse_out: expected %0d, got %0d", e.pulse, data[11:0]);
      fails++;
    end
    if (data[25:12] !== e.angle) begin
      $error("angle_out: expected %0d, got %0d", $signed(e.angle),
             $signed(data[25:12]));
      fails++;
    end
    if (data[26] !== e.busy) begin
      $error("busy_res: expected %0d, got %0d", e.busy, data[26]);
      fails++;
    end
  endfunction
endclass

module servo_calibrated_position_command_tb;
  import scpc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  servo_cmd_scoreboard sb = new();

  // Pacing knobs: steady modes turn the random gaps off, and a long hold
  // makes the receiver stall for a long stretch so the block backs up.
  bit sender_steady = 1'b0;
  bit recv_steady   = 1'b0;
  bit long_hold     = 1'b0;
  int sent          = 0;
  int cycles        = 0;

  servo_calibrated_position_command dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Watchdog: the slowest legal run is far below this many cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("servo_calibrated_position_command_tb: FAIL");
      $finish;
    end
  end

  // Response side. The stall before each response is drawn per request; a
  // long hold is counted here, while the sender keeps offering requests.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        stall = 300;
        long_hold = 1'b0;
      end else begin
        stall = recv_steady ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_response(m_axis_tuser, m_axis_tdata);
    end
  end

  // Offers one request after a random gap (none when steady) and returns on
  // the edge that accepts it. The valid stays high when the next gap is zero.
  task automatic send(req_t kind, logic [3:0] idx, logic [13:0] ang,
                      logic [11:0] pul);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, pul, ang, idx};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(kind, idx, ang, pul);
    sent++;
  endtask

  // Waits until every response is in, then lets the longest command finish
  // before anything else happens.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.configure(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Fills all 16 entries so that no point count can read an unset entry.
  // An ordered table has rising angles and pulses; a noisy one need not.
  task automatic load_table(bit noisy);
    logic [13:0] a;
    logic [11:0] p;
    for (int i = 0; i < 16; i++) begin
      a = 14'(-5760 + i * 720 + $urandom_range(0, 700));
      p = 12'(300 + i * 160 + $urandom_range(0, 150));
      if (noisy && $urandom_range(0, 2) == 0) begin
        a = 14'($urandom_range(0, 16383));
        p = 12'($urandom_range(0, 4095));
      end
      send(REQ_LOAD, 4'(i), a, p);
    end
  endtask

  task automatic random_request();
    int          pick;
    logic [3:0]  idx;
    logic [13:0] a;
    logic [11:0] p;
    pick = $urandom_range(0, 99);
    idx  = 4'($urandom_range(0, 15));
    a    = ($urandom_range(0, 4) == 0) ? 14'($urandom_range(0, 16383))
                                       : 14'($signed($urandom_range(0, 11520)) - 5760);
    p    = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                       : 12'($urandom_range(300, 2800));
    if (pick < 35) begin
      send(REQ_TICK, idx, a, p);
    end else if (pick < 60) begin
      send(REQ_ANGLE, idx, a, p);
    end else if (pick < 85) begin
      send(REQ_PULSE, idx, a, p);
    end else begin
      // Reload one point near its ordered position most of the time.
      if ($urandom_range(0, 3) != 0) begin
        a = 14'(-5760 + idx * 720 + $urandom_range(0, 700));
        p = 12'(300 + idx * 160 + $urandom_range(0, 150));
      end
      send(REQ_LOAD, idx, a, p);
    end
  endtask

  initial begin
    logic [15:0] pc_set[6];
    logic [15:0] min_set[6];
    logic [15:0] max_set[6];
    logic [15:0] ms_set[6];
    logic [15:0] ang_set[6];
    pc_set  = '{16'd16, 16'd2, 16'd0, 16'd31, 16'd5, 16'd9};
    min_set = '{16'd1, 16'd500, 16'd1000, 16'd600, 16'd1, 16'd2999};
    max_set = '{16'd2999, 16'd2500, 16'd800, 16'd2400, 16'd2999, 16'd2999};
    ms_set  = '{16'hFFFF, 16'd0, 16'd1280, 16'($urandom), 16'd0, 16'($urandom)};
    ang_set = '{16'(-5760), 16'(5760), 16'd0, 16'($urandom_range(0, 11520) - 5760),
                16'd100, 16'(-1)};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset register values: a full ordered table,
    // then extremes of every field and each kind of request.
    load_table(1'b0);
    send(REQ_ANGLE, 4'hF, 14'h2000, 12'd0);       // most negative angle
    send(REQ_ANGLE, 4'h0, 14'h1FFF, 12'hFFF);     // most positive angle
    send(REQ_PULSE, 4'h5, 14'h0000, 12'd0);       // zero pulse is refused
    send(REQ_PULSE, 4'h5, 14'h3FFF, 12'hFFF);     // above the ceiling
    send(REQ_PULSE, 4'h0, 14'h0000, 12'd1500);
    send(REQ_TICK, 4'hA, 14'h1555, 12'hAAA);
    send(REQ_LOAD, 4'hF, 14'h2000, 12'hFFF);
    // Entry 1 gets the most negative angle, which gives a falling first segment.
    send(REQ_LOAD, 4'h1, s_axis_tdata[17:4], 12'd2000);
    send(REQ_ANGLE, 4'h0, s_axis_tdata[17:4], 12'd0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      sender_steady = (ph == 0);
      recv_steady   = (ph == 0);
      write_reg(CFG_POINT_COUNT, pc_set[ph]);
      write_reg(CFG_MIN_PULSE, min_set[ph]);
      write_reg(CFG_MAX_PULSE, max_set[ph]);
      write_reg(CFG_MS_PER_DEG, ms_set[ph]);
      write_reg(CFG_INIT_ANGLE, ang_set[ph]);
      load_table(ph == 4);
      for (int i = 0; i < 44; i++) begin
        if (ph == 1 && i == 10) begin
          // Receiver stops for a long stretch while requests keep coming.
          long_hold     = 1'b1;
          sender_steady = 1'b1;
        end
        if (ph == 1 && i == 30) sender_steady = 1'b0;
        if (ph == 3 && i == 22) begin
          // Sender pauses until the block has answered everything.
          s_axis_tvalid <= 1'b0;
          while (sb.exp_q.size() != 0) @(posedge clk);
        end
        if (ph == 4 && i >= 20) send(REQ_TICK, 4'(i), 14'(i), 12'(i));
        else random_request();
      end
      drain();
    end

    $display("Sent %0d requests over 6 register settings plus a directed set;",
             sent);
    $display("checked %0d responses with %0d mismatches.", sb.checked, sb.fails);
    if (sb.fails == 0 && sb.exp_q.size() == 0) begin
      $display("servo_calibrated_position_command_tb: PASS");
    end else begin
      $display("servo_calibrated_position_command_tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
